// ===== rtl/core/skrt_pkg.sv =====
// shared types and constants for the sorted keyed record table
// no dependencies; imported by every module of the block
package skrt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int PAY_W    = 64;
  localparam int CMD_W    = 2;
  localparam int STAT_W   = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_SHOW = 2'd2,
    CMD_LIST = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_ADDED     = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_DELETED   = 3'd2,
    STAT_NOT_FOUND = 3'd3,
    STAT_FULL      = 3'd4,
    STAT_RECORD    = 3'd5,
    STAT_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHR,
    S_SHL,
    S_PUT,
    S_LIST_LD,
    S_LIST_WAIT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] first;
    logic [PAY_W-1:0] second;
  } record_t;

  typedef struct packed {
    logic eq;
    logic ge;
  } cmp_res_t;

endpackage

// ===== rtl/core/sorted_keyed_record_table.sv =====
// Sorted keyed record table, top level.
// Holds up to CAPACITY records (signed 32-bit key, two 64-bit payload words)
// in one record memory kept in ascending signed key order.
// Request channel: in_valid/in_ready with in_command (add, delete, show,
// list), in_record_key and the two payload words. Result channel:
// out_valid/out_ready with status, key, payload words and last_of_run.
// One request is worked at a time; in_ready is high only while idle.
// Add/delete/show first scan the memory one entry per cycle through the
// shared key comparator (stops at the first key >= request or at the end).
// Add then moves the tail up one slot and delete moves it down, one record
// per cycle after a first read of the registered memory, before the result
// shows. List emits the records in key order, each loaded from memory and
// then held until taken.
// Reset clears the entry count and returns to idle; memory contents are
// not cleared. A stalled result holds steady until taken, and no new
// request is accepted until the last result of the current one is taken.
module sorted_keyed_record_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [skrt_pkg::CMD_W-1:0]         in_command,
  input  logic [skrt_pkg::KEY_W-1:0]         in_record_key,
  input  logic [skrt_pkg::PAY_W-1:0]         in_first_payload,
  input  logic [skrt_pkg::PAY_W-1:0]         in_second_payload,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [skrt_pkg::STAT_W-1:0]        out_status,
  output logic [skrt_pkg::KEY_W-1:0]         out_key,
  output logic [skrt_pkg::PAY_W-1:0]         out_first,
  output logic [skrt_pkg::PAY_W-1:0]         out_second,
  output logic                               out_last_of_run
);
  import skrt_pkg::*;

  state_t             state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   first_r, first_nxt;
  logic [PAY_W-1:0]   second_r, second_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [IDX_W-1:0]   src_r, src_nxt;
  logic [IDX_W-1:0]   wp_r, wp_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               vld_r, vld_nxt;

  status_t            ost_r, ost_nxt;
  logic [KEY_W-1:0]   okey_r, okey_nxt;
  logic [PAY_W-1:0]   ofirst_r, ofirst_nxt;
  logic [PAY_W-1:0]   osecond_r, osecond_nxt;
  logic               olast_r, olast_nxt;

  record_t            mem [CAPACITY];
  record_t            rd_data_r;
  logic [IDX_W-1:0]   mem_raddr;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  record_t            mem_wdata;

  cmp_res_t           cmp;
  logic               accept;
  logic               out_take;
  logic               empty;
  logic               full;
  logic               scan_stop;
  logic [CNT_W-1:0]   idx_m1;
  logic [IDX_W-1:0]   scan_pos;
  logic               shr_done;
  logic               shl_done;
  cmd_t               in_cmd;

  // record memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  skrt_key_cmp u_cmp (
    .stored_key (rd_data_r.key),
    .req_key    (key_r),
    .res        (cmp)
  );

  assign in_cmd    = cmd_t'(in_command);
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_RESP) || (state_r == S_LIST_WAIT);
  assign accept    = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;
  assign empty     = (count_r == '0);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign idx_m1    = idx_r - CNT_W'(1);

  // compare result belongs to entry idx_r-1; stop at first key >= request or after the last entry
  assign scan_stop = (state_r == S_SCAN) && vld_r && (cmp.ge || (idx_r == count_r));
  assign scan_pos  = cmp.ge ? idx_m1[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign shr_done  = vld_r && (wp_r == pos_r + IDX_W'(1));
  assign shl_done  = vld_r && (wp_r == IDX_W'(count_r - CNT_W'(2)));

  assign out_status      = ost_r;
  assign out_key         = okey_r;
  assign out_first       = ofirst_r;
  assign out_second      = osecond_r;
  assign out_last_of_run = olast_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (empty) begin
            state_nxt = (in_cmd == CMD_ADD) ? S_PUT : S_RESP;
          end else if (in_cmd == CMD_LIST) begin
            state_nxt = S_LIST_LD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          case (cmd_r)
            CMD_ADD: begin
              if (cmp.eq || full) state_nxt = S_RESP;
              else if (!cmp.ge)   state_nxt = S_PUT;
              else                state_nxt = S_SHR;
            end
            CMD_DEL: begin
              if (cmp.eq && (idx_r != count_r)) state_nxt = S_SHL;
              else                              state_nxt = S_RESP;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_SHR: begin
        if (shr_done) state_nxt = S_PUT;
      end
      S_SHL: begin
        if (shl_done) state_nxt = S_RESP;
      end
      S_PUT:     state_nxt = S_RESP;
      S_LIST_LD: state_nxt = S_LIST_WAIT;
      S_LIST_WAIT: begin
        if (out_take) state_nxt = olast_r ? S_IDLE : S_LIST_LD;
      end
      S_RESP: begin
        if (out_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cmd_nxt     = cmd_r;
    key_nxt     = key_r;
    first_nxt   = first_r;
    second_nxt  = second_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    src_nxt     = src_r;
    wp_nxt      = wp_r;
    pos_nxt     = pos_r;
    vld_nxt     = vld_r;
    ost_nxt     = ost_r;
    okey_nxt    = okey_r;
    ofirst_nxt  = ofirst_r;
    osecond_nxt = osecond_r;
    olast_nxt   = olast_r;
    mem_raddr   = '0;
    mem_we      = 1'b0;
    mem_waddr   = wp_r;
    mem_wdata   = rd_data_r;

    case (state_r)
      S_IDLE: begin
        // address 0 is read while idle so a list can start at once
        if (accept) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_record_key;
          first_nxt   = in_first_payload;
          second_nxt  = in_second_payload;
          idx_nxt     = '0;
          vld_nxt     = 1'b0;
          pos_nxt     = '0;
          okey_nxt    = in_record_key;
          ofirst_nxt  = '0;
          osecond_nxt = '0;
          olast_nxt   = 1'b1;
          case (in_cmd)
            CMD_DEL:  ost_nxt = STAT_EMPTY;
            CMD_SHOW: ost_nxt = STAT_NOT_FOUND;
            CMD_LIST: begin
              ost_nxt  = STAT_EMPTY;
              okey_nxt = '0;
            end
            default:  ost_nxt = STAT_ADDED;
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = idx_r[IDX_W-1:0];
        if (!scan_stop) begin
          idx_nxt = idx_r + CNT_W'(1);
          vld_nxt = 1'b1;
        end else begin
          pos_nxt = scan_pos;
          vld_nxt = 1'b0;
          case (cmd_r)
            CMD_ADD: begin
              src_nxt = IDX_W'(count_r - CNT_W'(1));
              wp_nxt  = count_r[IDX_W-1:0];
              if (cmp.eq)    ost_nxt = STAT_DUPLICATE;
              else if (full) ost_nxt = STAT_FULL;
              else           ost_nxt = STAT_ADDED;
            end
            CMD_DEL: begin
              src_nxt = scan_pos + IDX_W'(1);
              wp_nxt  = scan_pos;
              if (!cmp.eq) begin
                ost_nxt = STAT_NOT_FOUND;
              end else begin
                ost_nxt = STAT_DELETED;
                // last entry removed needs no moves
                if (idx_r == count_r) count_nxt = count_r - CNT_W'(1);
              end
            end
            default: begin
              if (cmp.eq) begin
                ost_nxt     = STAT_RECORD;
                okey_nxt    = rd_data_r.key;
                ofirst_nxt  = rd_data_r.first;
                osecond_nxt = rd_data_r.second;
              end else begin
                ost_nxt = STAT_NOT_FOUND;
              end
            end
          endcase
        end
      end
      S_SHR: begin
        mem_raddr = src_r;
        if (!vld_r) begin
          src_nxt = src_r - IDX_W'(1);
          vld_nxt = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (!shr_done) begin
            wp_nxt  = wp_r - IDX_W'(1);
            src_nxt = src_r - IDX_W'(1);
          end
        end
      end
      S_SHL: begin
        mem_raddr = src_r;
        if (!vld_r) begin
          src_nxt = src_r + IDX_W'(1);
          vld_nxt = 1'b1;
        end else begin
          mem_we = 1'b1;
          if (shl_done) begin
            count_nxt = count_r - CNT_W'(1);
          end else begin
            wp_nxt  = wp_r + IDX_W'(1);
            src_nxt = src_r + IDX_W'(1);
          end
        end
      end
      S_PUT: begin
        mem_we           = 1'b1;
        mem_waddr        = pos_r;
        mem_wdata.key    = key_r;
        mem_wdata.first  = first_r;
        mem_wdata.second = second_r;
        count_nxt        = count_r + CNT_W'(1);
      end
      S_LIST_LD: begin
        mem_raddr   = idx_r[IDX_W-1:0];
        ost_nxt     = STAT_RECORD;
        okey_nxt    = rd_data_r.key;
        ofirst_nxt  = rd_data_r.first;
        osecond_nxt = rd_data_r.second;
        olast_nxt   = ((idx_r + CNT_W'(1)) == count_r);
      end
      S_LIST_WAIT: begin
        // prefetch the next entry so it is ready when this one is taken
        mem_raddr = idx_r[IDX_W-1:0] + IDX_W'(1);
        if (out_take) idx_nxt = idx_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      vld_r   <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    key_r     <= key_nxt;
    first_r   <= first_nxt;
    second_r  <= second_nxt;
    idx_r     <= idx_nxt;
    src_r     <= src_nxt;
    wp_r      <= wp_nxt;
    pos_r     <= pos_nxt;
    ost_r     <= ost_nxt;
    okey_r    <= okey_nxt;
    ofirst_r  <= ofirst_nxt;
    osecond_r <= osecond_nxt;
    olast_r   <= olast_nxt;
  end

endmodule

// ===== rtl/core/skrt_key_cmp.sv =====
// shared key comparator: equality and signed greater-or-equal
// depends on skrt_pkg
module skrt_key_cmp (
  input  logic [skrt_pkg::KEY_W-1:0] stored_key,
  input  logic [skrt_pkg::KEY_W-1:0] req_key,
  output skrt_pkg::cmp_res_t         res
);
  import skrt_pkg::*;

  always_comb begin
    res.eq = (stored_key == req_key);
    res.ge = ($signed(stored_key) >= $signed(req_key));
  end

endmodule

// ===== rtl/core/skrt_chk.sv =====
// port-level checker for the sorted keyed record table, with its bind
// depends on skrt_pkg and the top level sorted_keyed_record_table
module skrt_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [skrt_pkg::STAT_W-1:0] out_status,
  input logic [skrt_pkg::KEY_W-1:0]  out_key,
  input logic                        out_last_of_run
);
  import skrt_pkg::*;

  // one request at a time: never ready while a result is pending
  a_busy_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("ready while a result is pending");

  // an accepted request keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after accepting a request");

  // only list records can be non-final
  a_single_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STAT_RECORD)) |-> out_last_of_run)
    else $error("single result without last flag");

  // a taken non-final list record means more results follow
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_of_run) |=> !in_ready)
    else $error("run ended without last flag");

  // stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) && $stable(out_key)))
    else $error("stalled result changed");

endmodule

bind sorted_keyed_record_table skrt_chk u_skrt_chk (.*);

// ===== dv/skrt_table_checker.sv =====
// result checker for the sorted keyed record table: watches both channels,
// keeps its own copy of the table and compares every result it sees
// depends on skrt_pkg
`timescale 1ns / 1ps

module skrt_table_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [skrt_pkg::CMD_W-1:0]  in_command,
  input  logic [skrt_pkg::KEY_W-1:0]  in_record_key,
  input  logic [skrt_pkg::PAY_W-1:0]  in_first_payload,
  input  logic [skrt_pkg::PAY_W-1:0]  in_second_payload,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [skrt_pkg::STAT_W-1:0] out_status,
  input  logic [skrt_pkg::KEY_W-1:0]  out_key,
  input  logic [skrt_pkg::PAY_W-1:0]  out_first,
  input  logic [skrt_pkg::PAY_W-1:0]  out_second,
  input  logic                        out_last_of_run,
  output int                          fail_count,
  output int                          pending_results
);
  import skrt_pkg::*;

  typedef struct {
    status_t          status;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] first;
    logic [PAY_W-1:0] second;
    logic             last;
  } result_t;

  record_t stored_rec [CAPACITY];
  int      stored_count = 0;
  result_t expected_q [$];
  int      mismatches = 0;

  function automatic int find_key(logic [KEY_W-1:0] k);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_rec[i].key == k) return i;
    end
    return stored_count;
  endfunction

  task automatic push_result(status_t st, logic [KEY_W-1:0] k, logic [PAY_W-1:0] f,
                             logic [PAY_W-1:0] s, logic last);
    result_t r;
    r.status = st;
    r.key    = k;
    r.first  = f;
    r.second = s;
    r.last   = last;
    expected_q.push_back(r);
  endtask

  task automatic predict_request(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] f,
                                 logic [PAY_W-1:0] s);
    int pos;
    pos = find_key(k);
    case (c)
      CMD_ADD: begin
        // duplicate wins over full
        if (pos < stored_count) begin
          push_result(STAT_DUPLICATE, k, '0, '0, 1'b1);
        end else if (stored_count >= CAPACITY) begin
          push_result(STAT_FULL, k, '0, '0, 1'b1);
        end else begin
          pos = 0;
          while (pos < stored_count && $signed(stored_rec[pos].key) < $signed(k)) pos++;
          for (int i = stored_count; i > pos; i--) stored_rec[i] = stored_rec[i-1];
          stored_rec[pos] = '{key: k, first: f, second: s};
          stored_count++;
          push_result(STAT_ADDED, k, '0, '0, 1'b1);
        end
      end
      CMD_DEL: begin
        if (stored_count == 0) begin
          push_result(STAT_EMPTY, k, '0, '0, 1'b1);
        end else if (pos >= stored_count) begin
          push_result(STAT_NOT_FOUND, k, '0, '0, 1'b1);
        end else begin
          for (int i = pos; i + 1 < stored_count; i++) stored_rec[i] = stored_rec[i+1];
          stored_count--;
          push_result(STAT_DELETED, k, '0, '0, 1'b1);
        end
      end
      CMD_SHOW: begin
        if (pos >= stored_count) begin
          push_result(STAT_NOT_FOUND, k, '0, '0, 1'b1);
        end else begin
          push_result(STAT_RECORD, stored_rec[pos].key, stored_rec[pos].first,
                      stored_rec[pos].second, 1'b1);
        end
      end
      default: begin
        if (stored_count == 0) begin
          push_result(STAT_EMPTY, '0, '0, '0, 1'b1);
        end else begin
          for (int i = 0; i < stored_count; i++) begin
            push_result(STAT_RECORD, stored_rec[i].key, stored_rec[i].first,
                        stored_rec[i].second, i + 1 == stored_count);
          end
        end
      end
    endcase
  endtask

  task automatic check_result();
    result_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: unexpected result status=%0d key=%h first=%h second=%h last=%b",
                 $time, out_status, out_key, out_first, out_second, out_last_of_run);
      end
      return;
    end
    want = expected_q.pop_front();
    if (out_status !== want.status || out_key !== want.key || out_first !== want.first ||
        out_second !== want.second || out_last_of_run !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $time);
        $display("  expected status=%0d key=%h first=%h second=%h last=%b",
                 want.status, want.key, want.first, want.second, want.last);
        $display("  actual   status=%0d key=%h first=%h second=%h last=%b",
                 out_status, out_key, out_first, out_second, out_last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stored_count = 0;
      expected_q.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) begin
        predict_request(cmd_t'(in_command), in_record_key, in_first_payload,
                        in_second_payload);
      end
    end
    pending_results <= expected_q.size();
    fail_count      <= mismatches;
  end

endmodule

// ===== dv/sorted_keyed_record_table_test.sv =====
// testbench top for the sorted keyed record table: clock, reset, request
// and result stimulus, timeout and verdict
// depends on skrt_pkg, sorted_keyed_record_table and skrt_table_checker
`timescale 1ns / 1ps

module sorted_keyed_record_table_test;
  import skrt_pkg::*;

  localparam int LIMIT_CYCLES = 500_000;
  localparam int LONG_HOLD    = 400;
  localparam int POOL_SIZE    = 40;
  localparam int ROUND_LEN    = 35;

  logic             clk               = 1'b0;
  logic             rst_n             = 1'b0;
  logic             in_valid          = 1'b0;
  logic             in_ready;
  cmd_t             in_command        = CMD_ADD;
  logic [KEY_W-1:0] in_record_key     = '0;
  logic [PAY_W-1:0] in_first_payload  = '0;
  logic [PAY_W-1:0] in_second_payload = '0;
  logic             out_valid;
  logic             out_ready         = 1'b0;
  logic [STAT_W-1:0] out_status;
  logic [KEY_W-1:0] out_key;
  logic [PAY_W-1:0] out_first;
  logic [PAY_W-1:0] out_second;
  logic             out_last_of_run;

  int fail_count;
  int pending_results;
  int cycle_count  = 0;
  int burst_left   = 0;
  bit hold_request = 1'b0;
  bit hold_done    = 1'b0;

  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sorted_keyed_record_table u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_record_key     (in_record_key),
    .in_first_payload  (in_first_payload),
    .in_second_payload (in_second_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_key           (out_key),
    .out_first         (out_first),
    .out_second        (out_second),
    .out_last_of_run   (out_last_of_run)
  );

  skrt_table_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_record_key     (in_record_key),
    .in_first_payload  (in_first_payload),
    .in_second_payload (in_second_payload),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_key           (out_key),
    .out_first         (out_first),
    .out_second        (out_second),
    .out_last_of_run   (out_last_of_run),
    .fail_count        (fail_count),
    .pending_results   (pending_results)
  );

  function automatic logic [PAY_W-1:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  // mostly keys from the pool so that hits are common
  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic cmd_t pick_command(int w_add, int w_del, int w_show);
    int r;
    r = $urandom_range(0, 99);
    if (r < w_add) return CMD_ADD;
    if (r < w_add + w_del) return CMD_DEL;
    if (r < w_add + w_del + w_show) return CMD_SHOW;
    return CMD_LIST;
  endfunction

  // called and returns at a falling edge
  task automatic send_request(cmd_t c, logic [KEY_W-1:0] k, logic [PAY_W-1:0] f,
                              logic [PAY_W-1:0] s);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk);
      end
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_command        <= c;
    in_record_key     <= k;
    in_first_payload  <= f;
    in_second_payload <= s;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random(cmd_t c);
    send_request(c, pick_key(), rand_payload(), rand_payload());
  endtask

  // result side: stall segments of random mode, plus one long hold-off
  initial begin : result_sink
    int seg_left;
    int mode;
    seg_left = 0;
    mode     = 0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (seg_left == 0) begin
        mode     = $urandom_range(0, 2);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int base;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table behavior
    send_request(CMD_LIST, 32'h0000_1111, '1, '1);
    send_request(CMD_DEL, 32'h0000_2222, '0, '0);
    send_request(CMD_SHOW, 32'h0000_3333, '0, '0);
    // key and payload extremes, signed ordering around zero
    send_request(CMD_ADD, 32'h8000_0000, '1, '1);
    send_request(CMD_ADD, 32'h7fff_ffff, '0, '0);
    send_request(CMD_ADD, 32'h0000_0000, rand_payload(), rand_payload());
    send_request(CMD_ADD, 32'hffff_ffff, rand_payload(), rand_payload());
    send_request(CMD_ADD, 32'h7fff_ffff, rand_payload(), rand_payload());
    send_request(CMD_SHOW, 32'h8000_0000, '0, '0);
    send_request(CMD_SHOW, 32'h7fff_ffff, '0, '0);
    send_request(CMD_SHOW, 32'h1234_5678, '0, '0);
    send_request(CMD_DEL, 32'h1234_5678, '0, '0);
    send_request(CMD_LIST, 32'h0000_0000, '0, '0);
    send_request(CMD_DEL, 32'h8000_0000, '0, '0);
    send_request(CMD_DEL, 32'h7fff_ffff, '0, '0);
    send_request(CMD_LIST, 32'hffff_ffff, '0, '0);
    send_request(CMD_DEL, 32'h0000_0000, '0, '0);
    send_request(CMD_DEL, 32'hffff_ffff, '0, '0);
    send_request(CMD_DEL, 32'hffff_ffff, '0, '0);
    send_request(CMD_LIST, 32'h5555_aaaa, '0, '0);

    // long result stall while requests keep coming
    hold_request = 1'b1;

    // fill with distinct pool keys until full and past it, then random adds, mostly duplicates, on a full table
    base = $urandom_range(0, POOL_SIZE - 1);
    for (int j = 0; j < POOL_SIZE; j++) begin
      if ($urandom_range(0, 9) == 0) send_random(CMD_SHOW);
      send_request(CMD_ADD, key_pool[(base + j) % POOL_SIZE], rand_payload(),
                   rand_payload());
    end
    repeat (4) send_random(CMD_ADD);
    send_random(CMD_LIST);

    // drain, mixed, refill
    repeat (ROUND_LEN) send_random(pick_command(10, 70, 10));
    repeat (ROUND_LEN) send_random(pick_command(35, 25, 25));
    repeat (ROUND_LEN) send_random(pick_command(65, 10, 15));
    in_valid <= 1'b0;

    while (pending_results != 0) @(posedge clk);
    repeat (2 * CAPACITY + 20) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
